// ----- rtl/core/cevq_pkg.sv -----
package cevq_pkg;

  localparam int DEPTH_W = 7;
  localparam int DROPS_W = 32;
  localparam int PAYLOAD_W = 64;
  localparam int MASK_W = 8;

  localparam logic REQ_ENQ  = 1'b0;
  localparam logic REQ_RECV = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_REFUSED = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MOP_NONE  = 2'd0,
    MOP_WRITE = 2'd1,
    MOP_READ  = 2'd2
  } mem_op_t;

  typedef struct packed {
    status_t              status;
    logic                 evicted;
    logic [DEPTH_W-1:0]   depth;
    logic [DROPS_W-1:0]   drops;
  } meta_t;

endpackage

// ----- rtl/core/cevq_front.sv -----
module cevq_front #(
  parameter int NUM_CHANNELS = 8,
  parameter int QUEUE_SLOTS = 128,
  parameter int MEM_AW = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cevq_pkg::MASK_W-1:0]      cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             req_type,
  input  logic [7:0]                       channel,
  input  logic [cevq_pkg::PAYLOAD_W-1:0]   payload,
  output logic                             cmd_valid,
  input  logic                             cmd_ready,
  output cevq_pkg::mem_op_t                cmd_op,
  output logic [MEM_AW-1:0]                cmd_addr,
  output logic [cevq_pkg::PAYLOAD_W-1:0]   cmd_wdata,
  output cevq_pkg::meta_t                  cmd_meta
);
  import cevq_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PTR_W = $clog2(QUEUE_SLOTS);

  logic [PTR_W-1:0]   rd_ptr [NUM_CHANNELS];
  logic [PTR_W-1:0]   wr_ptr [NUM_CHANNELS];
  logic [DROPS_W-1:0] drop_count;
  logic [MASK_W-1:0]  mask;

  logic               accept;
  logic               ch_ok;
  logic               oldest;
  logic [CH_W-1:0]    ch_idx;
  logic [PTR_W-1:0]   r;
  logic [PTR_W-1:0]   w;
  logic [PTR_W-1:0]   r_next;
  logic [PTR_W-1:0]   w_next;
  logic               upd_r;
  logic               upd_w;
  logic               upd_drop;
  logic [PTR_W-1:0]   mem_ptr;
  logic [DROPS_W-1:0] drop_count_next;
  logic [PTR_W-1:0]   fill;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] res;
    res = (p == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : p + 1'b1;
    return res;
  endfunction

  function automatic logic [PTR_W-1:0] ring_fill(input logic [PTR_W-1:0] wp,
                                                 input logic [PTR_W-1:0] rp);
    logic [PTR_W:0] t;
    t = {1'b0, wp} + (PTR_W+1)'(QUEUE_SLOTS) - {1'b0, rp};
    if (wp >= rp) begin
      t = {1'b0, wp} - {1'b0, rp};
    end
    return t[PTR_W-1:0];
  endfunction

  function automatic logic [DEPTH_W-1:0] to_depth(input logic [PTR_W-1:0] f);
    logic [DEPTH_W+PTR_W-1:0] e;
    e = {{DEPTH_W{1'b0}}, f};
    return e[DEPTH_W-1:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign accept    = in_valid && cmd_ready;

  assign ch_ok  = {1'b0, channel} < 9'(NUM_CHANNELS);
  assign ch_idx = channel[CH_W-1:0];
  assign oldest = (channel < 8'(MASK_W)) && mask[channel[2:0]];
  assign r      = rd_ptr[ch_idx];
  assign w      = wr_ptr[ch_idx];

  always_comb begin
    cmd_op          = MOP_NONE;
    mem_ptr         = w;
    r_next          = r;
    w_next          = w;
    upd_r           = 1'b0;
    upd_w           = 1'b0;
    upd_drop        = 1'b0;
    drop_count_next = drop_count;
    fill            = '0;
    cmd_meta.status  = ST_DONE;
    cmd_meta.evicted = 1'b0;
    if (!ch_ok) begin
      cmd_meta.status = ST_INVALID;
    end else begin
      unique case (req_type)
        REQ_ENQ: begin
          if (ring_next(w) != r) begin
            cmd_op = MOP_WRITE;
            w_next = ring_next(w);
            upd_w  = 1'b1;
            fill   = ring_fill(ring_next(w), r);
          end else if (oldest) begin
            cmd_op = MOP_WRITE;
            w_next = ring_next(w);
            r_next = ring_next(r);
            upd_w  = 1'b1;
            upd_r  = 1'b1;
            cmd_meta.evicted = 1'b1;
            fill   = PTR_W'(QUEUE_SLOTS - 1);
          end else begin
            cmd_meta.status = ST_REFUSED;
            upd_drop = 1'b1;
            if (drop_count != '1) begin
              drop_count_next = drop_count + 1'b1;
            end
            fill = PTR_W'(QUEUE_SLOTS - 1);
          end
        end
        REQ_RECV: begin
          if (r == w) begin
            cmd_meta.status = ST_REFUSED;
          end else begin
            cmd_op  = MOP_READ;
            mem_ptr = r;
            r_next  = ring_next(r);
            upd_r   = 1'b1;
            fill    = ring_fill(w, ring_next(r));
          end
        end
        default: begin
          cmd_meta.status = ST_INVALID;
        end
      endcase
    end
    cmd_meta.depth = to_depth(fill);
    cmd_meta.drops = drop_count_next;
  end

  assign cmd_addr  = MEM_AW'(ch_idx) * MEM_AW'(QUEUE_SLOTS) + MEM_AW'(mem_ptr);
  assign cmd_wdata = payload;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        rd_ptr[i] <= '0;
        wr_ptr[i] <= '0;
      end
      drop_count <= '0;
      mask       <= '0;
    end else begin
      if (cfg_valid) begin
        mask <= cfg_data;
      end
      if (accept && upd_r) begin
        rd_ptr[ch_idx] <= r_next;
      end
      if (accept && upd_w) begin
        wr_ptr[ch_idx] <= w_next;
      end
      if (accept && upd_drop) begin
        drop_count <= drop_count_next;
      end
    end
  end

endmodule

// ----- rtl/core/cevq_queue.sv -----
module cevq_queue #(
  parameter int WIDTH = 8,
  parameter int ENTRIES = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic [WIDTH-1:0] slots [ENTRIES];
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  function automatic logic [IDX_W-1:0] step(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] res;
    res = (p == IDX_W'(ENTRIES - 1)) ? '0 : p + 1'b1;
    return res;
  endfunction

  assign in_ready  = count != CNT_W'(ENTRIES);
  assign out_valid = count != '0;
  assign out_data  = slots[head];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= step(tail);
      end
      if (pop) begin
        head <= step(head);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/cevq_back.sv -----
module cevq_back #(
  parameter int MEM_AW = 10,
  parameter int MEM_DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  output logic                             cmd_ready,
  input  cevq_pkg::mem_op_t                cmd_op,
  input  logic [MEM_AW-1:0]                cmd_addr,
  input  logic [cevq_pkg::PAYLOAD_W-1:0]   cmd_wdata,
  input  cevq_pkg::meta_t                  cmd_meta,
  output logic                             out_valid,
  input  logic                             out_ready,
  output cevq_pkg::meta_t                  out_meta,
  output logic [cevq_pkg::PAYLOAD_W-1:0]   out_payload
);
  import cevq_pkg::*;

  logic [PAYLOAD_W-1:0] mem [MEM_DEPTH];
  logic [PAYLOAD_W-1:0] rd_data;
  logic                 rd_sel;
  logic                 pop;

  assign cmd_ready   = !out_valid || out_ready;
  assign pop         = cmd_valid && cmd_ready;
  assign out_payload = rd_sel ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (pop && cmd_op == MOP_WRITE) begin
      mem[cmd_addr] <= cmd_wdata;
    end
    if (pop && cmd_op == MOP_READ) begin
      rd_data <= mem[cmd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_meta <= cmd_meta;
      rd_sel   <= cmd_op == MOP_READ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_ready) begin
      out_valid <= cmd_valid;
    end
  end

endmodule

// ----- rtl/core/channel_event_queues.sv -----
// Per-channel ring FIFOs of 64-bit event items with a drop-oldest or
// drop-newest policy per channel.
// Request channel: in_valid/in_ready with req_type (0 enqueue, 1 receive),
// channel and payload. Result channel: out_valid/out_ready with status,
// evicted, out_payload, depth and drops, one result per request, in order.
// Config channel: cfg_valid/cfg_ready with cfg_data, the drop-oldest mask;
// cfg_ready is always high.
// Path: the front classifies each request into a 4-entry command queue,
// then the back makes one slot-memory access with a registered read and
// holds the result in its output register.
// Throughput: one request per cycle while the command queue has room, set
// by the single port of the slot memory, which takes one access per item.
// Reset clears all ring pointers, the drop counter and the mask at once;
// the slot memory needs no clearing and requests are taken right after reset.
// When the receiver stalls the result register holds, the command queue
// fills, and in_ready drops once its four entries are taken.
module channel_event_queues #(
  parameter int NUM_CHANNELS = 8,
  parameter int QUEUE_SLOTS = 128
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cevq_pkg::MASK_W-1:0]      cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             req_type,
  input  logic [7:0]                       channel,
  input  logic [cevq_pkg::PAYLOAD_W-1:0]   payload,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       status,
  output logic                             evicted,
  output logic [cevq_pkg::PAYLOAD_W-1:0]   out_payload,
  output logic [cevq_pkg::DEPTH_W-1:0]     depth,
  output logic [cevq_pkg::DROPS_W-1:0]     drops
);
  import cevq_pkg::*;

  localparam int MEM_DEPTH = NUM_CHANNELS * QUEUE_SLOTS;
  localparam int MEM_AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int META_W = $bits(meta_t);
  localparam int CMD_W = 2 + MEM_AW + PAYLOAD_W + META_W;
  localparam int CMDQ_ENTRIES = 4;

  logic                 f_valid;
  logic                 f_ready;
  mem_op_t              f_op;
  logic [MEM_AW-1:0]    f_addr;
  logic [PAYLOAD_W-1:0] f_wdata;
  meta_t                f_meta;

  logic                 b_valid;
  logic                 b_ready;
  mem_op_t              b_op;
  logic [MEM_AW-1:0]    b_addr;
  logic [PAYLOAD_W-1:0] b_wdata;
  meta_t                b_meta;
  logic [CMD_W-1:0]     b_data;
  meta_t                o_meta;

  cevq_front #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .QUEUE_SLOTS (QUEUE_SLOTS),
    .MEM_AW      (MEM_AW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .channel  (channel),
    .payload  (payload),
    .cmd_valid(f_valid),
    .cmd_ready(f_ready),
    .cmd_op   (f_op),
    .cmd_addr (f_addr),
    .cmd_wdata(f_wdata),
    .cmd_meta (f_meta)
  );

  cevq_queue #(
    .WIDTH  (CMD_W),
    .ENTRIES(CMDQ_ENTRIES)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .in_data  ({f_op, f_addr, f_wdata, f_meta}),
    .out_valid(b_valid),
    .out_ready(b_ready),
    .out_data (b_data)
  );

  assign b_op    = mem_op_t'(b_data[CMD_W-1 -: 2]);
  assign b_addr  = b_data[CMD_W-3 -: MEM_AW];
  assign b_wdata = b_data[META_W +: PAYLOAD_W];
  assign b_meta  = b_data[META_W-1:0];

  cevq_back #(
    .MEM_AW   (MEM_AW),
    .MEM_DEPTH(MEM_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (b_valid),
    .cmd_ready  (b_ready),
    .cmd_op     (b_op),
    .cmd_addr   (b_addr),
    .cmd_wdata  (b_wdata),
    .cmd_meta   (b_meta),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_meta   (o_meta),
    .out_payload(out_payload)
  );

  assign status  = o_meta.status;
  assign evicted = o_meta.evicted;
  assign depth   = o_meta.depth;
  assign drops   = o_meta.drops;

endmodule

// ----- tb/sv/channel_event_queues_test.sv -----
`timescale 1ns / 100ps

module channel_event_queues_test;
  import cevq_pkg::*;

  localparam int NUM_CH = 8;
  localparam int SLOTS = 128;
  localparam int RING_CAP = SLOTS - 1;
  localparam int TOTAL_REQUESTS = 1900;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [7:0] FULL_CH = 8'd3;

  typedef struct {
    status_t status;
    logic evicted;
    logic [PAYLOAD_W-1:0] data;
    logic [DEPTH_W-1:0] depth;
    logic [DROPS_W-1:0] drops;
  } queue_outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [MASK_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = REQ_ENQ;
  logic [7:0] channel = '0;
  logic [PAYLOAD_W-1:0] payload = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic evicted;
  logic [PAYLOAD_W-1:0] out_payload;
  logic [DEPTH_W-1:0] depth;
  logic [DROPS_W-1:0] drops;

  logic [PAYLOAD_W-1:0] slot_mem [0:NUM_CH*SLOTS-1];
  logic [6:0] head_ptr [0:NUM_CH-1];
  logic [6:0] tail_ptr [0:NUM_CH-1];
  logic [DROPS_W-1:0] drop_total = '0;
  logic [MASK_W-1:0] drop_mask = '0;

  queue_outcome_t pending_outcomes [$];
  queue_outcome_t oldest_outcome;
  int failures = 0;
  int sent_count = 0;
  int cycle_count = 0;
  int hold_request = 0;
  int burst_left = 0;
  bit gaps_on = 1'b0;

  channel_event_queues #(
    .NUM_CHANNELS(NUM_CH),
    .QUEUE_SLOTS(SLOTS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .channel(channel),
    .payload(payload),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .evicted(evicted),
    .out_payload(out_payload),
    .depth(depth),
    .drops(drops)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    for (int c = 0; c < NUM_CH; c++) begin
      head_ptr[c] = '0;
      tail_ptr[c] = '0;
    end
  end

  function automatic queue_outcome_t apply_request(input logic kind, input logic [7:0] ch,
                                                   input logic [PAYLOAD_W-1:0] data);
    queue_outcome_t r;
    logic [2:0] c;
    logic [6:0] next_tail;
    r.status = ST_DONE;
    r.evicted = 1'b0;
    r.data = '0;
    r.depth = '0;
    if (ch >= NUM_CH) begin
      r.status = ST_INVALID;
    end else begin
      c = ch[2:0];
      if (kind == REQ_ENQ) begin
        next_tail = tail_ptr[c] + 7'd1;
        if (next_tail == head_ptr[c]) begin
          if (drop_mask[c]) begin
            head_ptr[c] = head_ptr[c] + 7'd1;
            r.evicted = 1'b1;
          end else begin
            r.status = ST_REFUSED;
            if (drop_total != '1) drop_total = drop_total + 1'b1;
          end
        end
        if (r.status == ST_DONE) begin
          slot_mem[{c, tail_ptr[c]}] = data;
          tail_ptr[c] = next_tail;
        end
      end else begin
        if (head_ptr[c] == tail_ptr[c]) begin
          r.status = ST_REFUSED;
        end else begin
          r.data = slot_mem[{c, head_ptr[c]}];
          head_ptr[c] = head_ptr[c] + 7'd1;
        end
      end
      r.depth = tail_ptr[c] - head_ptr[c];
    end
    r.drops = drop_total;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d depth %0d",
                 $time, status, depth);
        failures++;
      end else begin
        oldest_outcome = pending_outcomes.pop_front();
        compare_field("status", 64'(oldest_outcome.status), 64'(status));
        compare_field("evicted", 64'(oldest_outcome.evicted), 64'(evicted));
        compare_field("out_payload", oldest_outcome.data, out_payload);
        compare_field("depth", 64'(oldest_outcome.depth), 64'(depth));
        compare_field("drops", 64'(oldest_outcome.drops), 64'(drops));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : receiver_pacing
    int hold_left;
    int pattern_left;
    int stall_pct;
    hold_left = 0;
    pattern_left = 0;
    stall_pct = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end
      pattern_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic send_request(input logic kind, input logic [7:0] ch,
                              input logic [PAYLOAD_W-1:0] data);
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    req_type <= kind;
    channel <= ch;
    payload <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_outcomes.push_back(apply_request(kind, ch, data));
    sent_count++;
  endtask

  // hold the sender until every result is back, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mask(input logic [MASK_W-1:0] mask);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= mask;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    drop_mask = mask;
  endtask

  task automatic test_directed();
    int k;
    gaps_on = 1'b0;
    send_request(REQ_RECV, 8'd0, '0);
    send_request(REQ_ENQ, 8'd0, '0);
    send_request(REQ_ENQ, 8'd0, '1);
    send_request(REQ_ENQ, 8'd7, 64'hA5A5_A5A5_5A5A_5A5A);
    send_request(REQ_RECV, 8'd0, '1);
    send_request(REQ_RECV, 8'd0, '0);
    send_request(REQ_RECV, 8'd0, '0);
    send_request(REQ_RECV, 8'd7, '0);
    send_request(REQ_ENQ, 8'd8, '1);
    send_request(REQ_RECV, 8'd255, '1);
    send_request(REQ_ENQ, 8'd128, 64'h8000_0000_0000_0001);
    for (k = 1; k < 7; k++) send_request(REQ_ENQ, 8'(k), {64{1'b1}} >> k);
    for (k = 1; k < 7; k++) send_request(REQ_RECV, 8'(k), '0);
  endtask

  // fill one ring past capacity under both policies, then empty it
  task automatic test_ring_full();
    int k;
    write_mask(8'hF7);
    gaps_on = 1'b0;
    for (k = 0; k < RING_CAP + 2; k++) send_request(REQ_ENQ, FULL_CH, {$urandom, $urandom});
    write_mask(8'h08);
    gaps_on = 1'b1;
    repeat (3) send_request(REQ_ENQ, FULL_CH, {$urandom, $urandom});
    repeat (RING_CAP + 1) send_request(REQ_RECV, FULL_CH, {$urandom, $urandom});
  endtask

  task automatic test_backpressure();
    settle();
    gaps_on = 1'b0;
    hold_request = 150;
    repeat (40) begin
      send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, NUM_CH - 1)),
                   {$urandom, $urandom});
    end
    settle();
  endtask

  task automatic test_random_traffic();
    int phase_len;
    int enq_pct;
    int hot;
    logic kind;
    logic [7:0] ch;
    logic [MASK_W-1:0] mask;
    while (sent_count < TOTAL_REQUESTS) begin
      case ($urandom_range(0, 4))
        0: mask = 8'h00;
        1: mask = 8'hFF;
        2: mask = 8'h55;
        3: mask = 8'hAA;
        default: mask = MASK_W'($urandom_range(0, 255));
      endcase
      write_mask(mask);
      gaps_on = ($urandom_range(0, 3) != 0);
      hot = $urandom_range(0, NUM_CH - 1);
      case ($urandom_range(0, 2))
        0: enq_pct = 85;
        1: enq_pct = 15;
        default: enq_pct = 50;
      endcase
      phase_len = $urandom_range(120, 260);
      repeat (phase_len) begin
        kind = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQ : REQ_RECV;
        if ($urandom_range(0, 99) < 5) ch = 8'($urandom_range(NUM_CH, 255));
        else if ($urandom_range(0, 99) < 70) ch = 8'(hot);
        else ch = 8'($urandom_range(0, NUM_CH - 1));
        send_request(kind, ch, {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_ring_full();
    test_backpressure();
    test_random_traffic();
    settle();
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
